FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RBES_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rbes assertion failed");

`define RBES_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rbes forbidden condition seen");

`else

`define RBES_ASSERT(lbl, clk, rst_n, prop)

`define RBES_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: rtl/core/rbes_pkg.sv
// ---------------------------------------------------------------------------
// rbes_pkg
// Shared types, constants and micro-op decode for the rigid body integrator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbes_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int IO_W          = 32;
    localparam int CFG_W         = 24;
    localparam int CFG_FRAC      = 16;
    localparam int DT_W          = 16;
    localparam int MODE_W        = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int NUM_AXES      = 3;
    localparam int STEP_W        = 3;
    localparam int AXIS_W        = 2;

    localparam int MODE_GRAV = 0;
    localparam int MODE_AIR  = 1;
    localparam int MODE_FALL = 2;
    localparam int MODE_SPIN = 3;

    localparam logic [CFG_W-1:0]  CFG_ONE       = 24'h010000;
    localparam logic [AXIS_W-1:0] AXIS_Y        = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_LAST     = 2'd2;
    localparam logic [STEP_W-1:0] LIN_LAST_STEP = 3'd5;
    localparam logic [STEP_W-1:0] ANG_LAST_STEP = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_MASS,
        CFG_AIR_DRAG,
        CFG_FALL_DRAG,
        CFG_SPIN_DRAG,
        CFG_INV_INERTIA,
        CFG_GRAV_SCALE,
        CFG_MODE
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0]  inv_mass;
        logic [CFG_W-1:0]  air_drag;
        logic [CFG_W-1:0]  fall_drag;
        logic [CFG_W-1:0]  spin_drag;
        logic [CFG_W-1:0]  inv_inertia;
        logic [CFG_W-1:0]  grav_scale;
        logic [MODE_W-1:0] mode;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        inv_mass:    CFG_ONE,
        air_drag:    '0,
        fall_drag:   '0,
        spin_drag:   '0,
        inv_inertia: CFG_ONE,
        grav_scale:  CFG_ONE,
        mode:        '0
    };

    typedef struct packed {
        logic [NUM_AXES-1:0][IO_W-1:0] frc;
        logic [NUM_AXES-1:0][IO_W-1:0] trq;
        logic [DT_W-1:0]               dt;
    } t_tick;

    typedef struct packed {
        logic [NUM_AXES-1:0][IO_W-1:0] vel;
        logic [NUM_AXES-1:0][IO_W-1:0] pos;
        logic [NUM_AXES-1:0][IO_W-1:0] ang;
        logic                          sat;
    } t_result;

    typedef enum logic {SECT_LIN, SECT_ANG} t_sect;

    typedef enum logic [2:0] {
        X_VEL, X_SPIN, X_FORCE, X_TORQUE, X_T0, X_T1, X_GRAV
    } t_xsel;

    typedef enum logic [2:0] {
        C_DRAG, C_SPIN_DRAG, C_INV_MASS, C_INV_INERTIA, C_DT, C_ONE, C_GRAV
    } t_csel;

    typedef enum logic [2:0] {
        A_ZERO, A_T1, A_VEL, A_POS, A_SPIN
    } t_asel;

    typedef enum logic [2:0] {
        D_T0, D_T1, D_VEL, D_POS, D_SPIN, D_ANG
    } t_dsel;

    // dest = sat(addend +/- sat(floor(x * c / 2^16)))
    typedef struct packed {
        t_xsel xsel;
        t_csel csel;
        logic  neg;
        t_asel asel;
        t_dsel dsel;
    } t_uop;

    typedef struct packed {
        logic              load;
        logic              mul_en;
        logic              acc_en;
        logic              finish;
        logic [AXIS_W-1:0] axis;
        t_uop              uop;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    function automatic t_uop uop_decode(input t_sect sect, input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{xsel: X_T1, csel: C_ONE, neg: 1'b0, asel: A_ZERO, dsel: D_T1};
        if (sect == SECT_LIN) begin
            case (step)
                3'd0:    u = '{X_VEL,   C_DRAG,     1'b1, A_ZERO, D_T0};
                3'd1:    u = '{X_FORCE, C_INV_MASS, 1'b0, A_ZERO, D_T1};
                3'd2:    u = '{X_T0,    C_INV_MASS, 1'b0, A_T1,   D_T1};
                3'd3:    u = '{X_GRAV,  C_GRAV,     1'b1, A_T1,   D_T1};
                3'd4:    u = '{X_T1,    C_DT,       1'b0, A_VEL,  D_VEL};
                3'd5:    u = '{X_VEL,   C_DT,       1'b0, A_POS,  D_POS};
                default: ;
            endcase
        end else begin
            case (step)
                3'd0:    u = '{X_SPIN,   C_SPIN_DRAG,   1'b1, A_ZERO, D_T0};
                3'd1:    u = '{X_TORQUE, C_INV_INERTIA, 1'b0, A_ZERO, D_T1};
                3'd2:    u = '{X_T1,     C_DT,          1'b0, A_ZERO, D_T1};
                3'd3:    u = '{X_T0,     C_INV_INERTIA, 1'b0, A_ZERO, D_T0};
                3'd4:    u = '{X_T0,     C_DT,          1'b0, A_T1,   D_T1};
                3'd5:    u = '{X_T1,     C_ONE,         1'b0, A_SPIN, D_SPIN};
                3'd6:    u = '{X_SPIN,   C_DT,          1'b0, A_ZERO, D_ANG};
                default: ;
            endcase
        end
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rbes_tick_if.sv
// ---------------------------------------------------------------------------
// rbes_tick_if
// Input channel: one simulation tick of force, torque and time step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rbes_tick_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic        [15:0] step_seconds;

    modport source (
        output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
               step_seconds,
        input  ready
    );

    modport sink (
        input  valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
               step_seconds,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/rbes_result_if.sv
// ---------------------------------------------------------------------------
// rbes_result_if
// Output channel: new velocity, position, rotation angles and clamp flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rbes_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] pitch_angle;
    logic signed [31:0] yaw_angle;
    logic signed [31:0] roll_angle;
    logic               saturated;

    modport source (
        output valid, out_vel_x, out_vel_y, out_vel_z, out_pos_x, out_pos_y,
               out_pos_z, pitch_angle, yaw_angle, roll_angle, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_vel_x, out_vel_y, out_vel_z, out_pos_x, out_pos_y,
               out_pos_z, pitch_angle, yaw_angle, roll_angle, saturated,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/rbes_datapath.sv
// ---------------------------------------------------------------------------
// rbes_datapath
// Shared multiply/accumulate unit, body state, scratch and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbes_datapath import rbes_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    input  wire t_cfg       i_cfg,
    input  wire t_tick      i_tick,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output t_result         o_res
);

    localparam int W  = WORD_BITS;
    localparam int PW = WORD_BITS + CFG_W + 1;

    localparam longint W_MAX_L = (longint'(1) <<< (W - 1)) - 1;
    localparam longint W_MIN_L = -W_MAX_L - 1;
    localparam logic signed [W-1:0] W_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] W_MIN = {1'b1, {(W - 1){1'b0}}};

    // 9.8 rounded to nearest in the word format, clamped to the word
    localparam longint G_RAW = ((longint'(98) <<< FRAC_BITS) + 5) / 10;
    localparam logic signed [W-1:0] G_WORD = (G_RAW > W_MAX_L) ? W_MAX : G_RAW[W-1:0];

    function automatic logic in_clamps(input logic [IO_W-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        return (v > W_MAX_L) || (v < W_MIN_L);
    endfunction

    function automatic logic signed [W-1:0] take_in(input logic [IO_W-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v > W_MAX_L) begin
            return W_MAX;
        end else if (v < W_MIN_L) begin
            return W_MIN;
        end
        return v[W-1:0];
    endfunction

    function automatic logic [IO_W-1:0] to_io(input logic signed [W-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[IO_W-1:0];
    endfunction

    logic signed [W-1:0]  r_vel  [NUM_AXES];
    logic signed [W-1:0]  r_pos  [NUM_AXES];
    logic signed [W-1:0]  r_spin [NUM_AXES];
    logic signed [W-1:0]  r_ang  [NUM_AXES];
    logic signed [W-1:0]  r_frc  [NUM_AXES];
    logic signed [W-1:0]  r_trq  [NUM_AXES];
    logic [DT_W-1:0]      r_dt;
    logic signed [W-1:0]  r_t0;
    logic signed [W-1:0]  r_t1;
    logic signed [PW-1:0] r_prod;
    logic                 r_flag;
    logic                 r_out_valid;
    t_result              r_out;

    logic signed [W-1:0]  ld_frc [NUM_AXES];
    logic signed [W-1:0]  ld_trq [NUM_AXES];
    logic                 n_in_clamp;

    logic signed [W-1:0]  op_x;
    logic [CFG_W-1:0]     op_c;
    logic signed [PW-1:0] n_prod;

    logic signed [PW-1:0] sh;
    logic [PW-W:0]        sh_top;
    logic                 m_clamp;
    logic signed [W-1:0]  m;
    logic signed [W-1:0]  addend;
    logic [W-1:0]         mt;
    logic                 cin;
    logic                 neg_clamp;
    logic signed [W:0]    sum;
    logic                 add_clamp;
    logic signed [W-1:0]  res;
    logic                 acc_clamp;

    always_comb begin
        n_in_clamp = 1'b0;
        for (int a = 0; a < NUM_AXES; a++) begin
            ld_frc[a]  = take_in(i_tick.frc[a]);
            ld_trq[a]  = take_in(i_tick.trq[a]);
            n_in_clamp = n_in_clamp | in_clamps(i_tick.frc[a]) | in_clamps(i_tick.trq[a]);
        end
    end

    always_comb begin
        case (i_cmd.uop.xsel)
            X_VEL:    op_x = r_vel[i_cmd.axis];
            X_SPIN:   op_x = r_spin[i_cmd.axis];
            X_FORCE:  op_x = r_frc[i_cmd.axis];
            X_TORQUE: op_x = r_trq[i_cmd.axis];
            X_T0:     op_x = r_t0;
            X_T1:     op_x = r_t1;
            X_GRAV:   op_x = G_WORD;
            default:  op_x = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.uop.csel)
            C_DRAG: begin
                if (i_cmd.axis == AXIS_Y) begin
                    // fall drag only while moving down
                    op_c = (i_cfg.mode[MODE_FALL] && r_vel[AXIS_Y][W-1]) ? i_cfg.fall_drag : '0;
                end else begin
                    op_c = i_cfg.mode[MODE_AIR] ? i_cfg.air_drag : '0;
                end
            end
            C_SPIN_DRAG:   op_c = i_cfg.mode[MODE_SPIN] ? i_cfg.spin_drag : '0;
            C_INV_MASS:    op_c = i_cfg.inv_mass;
            C_INV_INERTIA: op_c = i_cfg.inv_inertia;
            C_DT:          op_c = {{(CFG_W - DT_W){1'b0}}, r_dt};
            C_ONE:         op_c = CFG_ONE;
            C_GRAV: begin
                op_c = (i_cmd.axis == AXIS_Y && i_cfg.mode[MODE_GRAV]) ? i_cfg.grav_scale : '0;
            end
            default:       op_c = '0;
        endcase
    end

    assign n_prod = $signed({{(PW - W){op_x[W-1]}}, op_x})
                  * $signed({{(PW - CFG_W){1'b0}}, op_c});

    // floor shift, clamp, optional negate, add, clamp
    always_comb begin
        sh      = r_prod >>> CFG_FRAC;
        sh_top  = sh[PW-1:W-1];
        m_clamp = !((&sh_top) || !(|sh_top));
        if (m_clamp) begin
            m = sh[PW-1] ? W_MIN : W_MAX;
        end else begin
            m = sh[W-1:0];
        end

        case (i_cmd.uop.asel)
            A_ZERO:  addend = '0;
            A_T1:    addend = r_t1;
            A_VEL:   addend = r_vel[i_cmd.axis];
            A_POS:   addend = r_pos[i_cmd.axis];
            A_SPIN:  addend = r_spin[i_cmd.axis];
            default: addend = '0;
        endcase

        // negating the most negative word gives the most positive one
        mt        = i_cmd.uop.neg ? ~m : m;
        cin       = i_cmd.uop.neg && (m != W_MIN);
        neg_clamp = i_cmd.uop.neg && (m == W_MIN);
        sum       = $signed({addend[W-1], addend}) + $signed({mt[W-1], mt})
                  + $signed({{W{1'b0}}, cin});
        add_clamp = sum[W] != sum[W-1];
        if (add_clamp) begin
            res = sum[W] ? W_MIN : W_MAX;
        end else begin
            res = sum[W-1:0];
        end
        acc_clamp = m_clamp | neg_clamp | add_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_vel[a]  <= '0;
                r_pos[a]  <= '0;
                r_spin[a] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.acc_en) begin
                case (i_cmd.uop.dsel)
                    D_VEL:   r_vel[i_cmd.axis]  <= res;
                    D_POS:   r_pos[i_cmd.axis]  <= res;
                    D_SPIN:  r_spin[i_cmd.axis] <= res;
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_frc[a] <= ld_frc[a];
                r_trq[a] <= ld_trq[a];
            end
            r_dt   <= i_tick.dt;
            r_flag <= n_in_clamp;
        end else if (i_cmd.acc_en) begin
            r_flag <= r_flag | acc_clamp;
        end

        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end

        if (i_cmd.acc_en) begin
            case (i_cmd.uop.dsel)
                D_T0:    r_t0 <= res;
                D_T1:    r_t1 <= res;
                D_ANG:   r_ang[i_cmd.axis] <= res;
                default: ;
            endcase
        end

        if (i_cmd.finish) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out.vel[a] <= to_io(r_vel[a]);
                r_out.pos[a] <= to_io(r_pos[a]);
                r_out.ang[a] <= to_io(r_ang[a]);
            end
            r_out.sat <= r_flag;
        end
    end

    assign o_status.out_free = !r_out_valid || i_res_ready;
    assign o_res_valid       = r_out_valid;
    assign o_res             = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/rbes_ctrl.sv
// ---------------------------------------------------------------------------
// rbes_ctrl
// Sequencer: walks the linear and angular micro-op programs per axis.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rbes_ctrl import rbes_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_DONE} t_state;

    t_state              r_state;
    t_sect               r_sect;
    logic [STEP_W-1:0]   r_step;
    logic [AXIS_W-1:0]   r_axis;
    logic                last_step;
    logic                in_xfer;
    logic                at_start;
    logic                done_wait;

    assign last_step  = (r_sect == SECT_LIN) ? (r_step == LIN_LAST_STEP)
                                             : (r_step == ANG_LAST_STEP);
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign at_start   = (r_state == S_MUL) && (r_step == '0) && (r_axis == '0)
                     && (r_sect == SECT_LIN);
    assign done_wait  = (r_state == S_DONE) && !i_status.out_free;

    always_comb begin
        o_cmd.load   = in_xfer;
        o_cmd.mul_en = (r_state == S_MUL);
        o_cmd.acc_en = (r_state == S_ACC);
        o_cmd.finish = (r_state == S_DONE) && i_status.out_free;
        o_cmd.axis   = r_axis;
        o_cmd.uop    = uop_decode(r_sect, r_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sect  <= SECT_LIN;
            r_step  <= '0;
            r_axis  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_MUL;
                        r_sect  <= SECT_LIN;
                        r_step  <= '0;
                        r_axis  <= '0;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= S_MUL;
                    if (last_step) begin
                        r_step <= '0;
                        if (r_axis == AXIS_LAST) begin
                            r_axis <= '0;
                            if (r_sect == SECT_LIN) begin
                                r_sect <= SECT_ANG;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RBES_ASSERT(a_mul_then_acc, i_clk, i_rst_n, (r_state == S_MUL) |=> (r_state == S_ACC))
    `RBES_ASSERT(a_start_clean, i_clk, i_rst_n, in_xfer |=> at_start)
    `RBES_ASSERT(a_done_holds, i_clk, i_rst_n, done_wait |=> (r_state == S_DONE))
    `RBES_ASSERT_NEVER(a_finish_blocked, i_clk, i_rst_n, o_cmd.finish && !i_status.out_free)

endmodule

`default_nettype wire

FILE: rtl/core/rigid_body_euler_step.sv
// ---------------------------------------------------------------------------
// rigid_body_euler_step
// Semi-implicit Euler integrator for one rigid body, Q16.16 fixed point.
// ---------------------------------------------------------------------------
// Each transfer on i_tick is one simulation tick; each produces exactly one
// transfer on o_result. The tick is computed as 39 multiply/accumulate
// micro-ops on a single shared multiplier, each a multiply step and then a
// floor/clamp/add step. After acceptance the micro-ops run in turn, then the
// result register is written once o_result has room. A new tick is accepted
// while the previous result still waits. Configuration registers must only
// be written while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rigid_body_euler_step import rbes_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    rbes_tick_if.sink                 i_tick,
    rbes_result_if.source             o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg       r_cfg;
    t_tick      tick_pl;
    t_result    res_pl;
    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;
    logic       res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INV_MASS:    r_cfg.inv_mass    <= i_cfg_data;
                CFG_AIR_DRAG:    r_cfg.air_drag    <= i_cfg_data;
                CFG_FALL_DRAG:   r_cfg.fall_drag   <= i_cfg_data;
                CFG_SPIN_DRAG:   r_cfg.spin_drag   <= i_cfg_data;
                CFG_INV_INERTIA: r_cfg.inv_inertia <= i_cfg_data;
                CFG_GRAV_SCALE:  r_cfg.grav_scale  <= i_cfg_data;
                CFG_MODE:        r_cfg.mode        <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign tick_pl.frc[0] = i_tick.force_x;
    assign tick_pl.frc[1] = i_tick.force_y;
    assign tick_pl.frc[2] = i_tick.force_z;
    assign tick_pl.trq[0] = i_tick.torque_x;
    assign tick_pl.trq[1] = i_tick.torque_y;
    assign tick_pl.trq[2] = i_tick.torque_z;
    assign tick_pl.dt     = i_tick.step_seconds;
    assign i_tick.ready   = in_ready;

    rbes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rbes_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg       (r_cfg),
        .i_tick      (tick_pl),
        .o_res_valid (res_valid),
        .i_res_ready (o_result.ready),
        .o_res       (res_pl)
    );

    assign o_result.valid       = res_valid;
    assign o_result.out_vel_x   = res_pl.vel[0];
    assign o_result.out_vel_y   = res_pl.vel[1];
    assign o_result.out_vel_z   = res_pl.vel[2];
    assign o_result.out_pos_x   = res_pl.pos[0];
    assign o_result.out_pos_y   = res_pl.pos[1];
    assign o_result.out_pos_z   = res_pl.pos[2];
    assign o_result.pitch_angle = res_pl.ang[0];
    assign o_result.yaw_angle   = res_pl.ang[1];
    assign o_result.roll_angle  = res_pl.ang[2];
    assign o_result.saturated   = res_pl.sat;

endmodule

`default_nettype wire
